// ----- rtl/dcf77_pulse_decoder_defines.svh -----
// Assertion macros shared by the DCF77 pulse decoder RTL.
`ifndef DCF77_PULSE_DECODER_DEFINES_SVH
`define DCF77_PULSE_DECODER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define DCF_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
    else $error(msg);

// Condition, then consequence in the next cycle.
`define DCF_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dcf_pkg.sv -----
// Shared constants, types and helpers of the DCF77 pulse decoder.
package dcf_pkg;

  // Port and register widths.
  localparam int IN_TIME_W     = 32;
  localparam int TIME_BITS_DEF = 32;
  localparam int JITTER_W      = 20;
  localparam int MINUTE_W      = 22;
  localparam int ONE_W         = 20;
  localparam int CFG_DATA_W    = 22;
  localparam int CFG_IDX_W     = 2;
  localparam int STORE_W       = 64;
  localparam int SEC_W         = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_PULSE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LEVEL = 2'd3;

  // Configuration reset values.
  localparam logic [JITTER_W-1:0] JITTER_GAP_RST = 20'd10000;
  localparam logic [MINUTE_W-1:0] MINUTE_GAP_RST = 22'd1500000;
  localparam logic [ONE_W-1:0]    ONE_PULSE_RST  = 20'd150000;
  localparam logic                INIT_LEVEL_RST = 1'b0;

  // Sync phase codes.
  localparam logic [1:0] PHASE_UNSYNCED = 2'd0;
  localparam logic [1:0] PHASE_INIT     = 2'd1;
  localparam logic [1:0] PHASE_STARTED  = 2'd2;

  // Highest second counter value; it saturates there.
  localparam logic [SEC_W-1:0] SEC_MAX = '1;

  // Bit positions of the time code fields in the bit store.
  localparam int MIN_U_POS = 21;
  localparam int MIN_T_POS = 25;
  localparam int HR_U_POS  = 29;
  localparam int HR_T_POS  = 33;
  localparam int DAY_U_POS = 36;
  localparam int DAY_T_POS = 40;
  localparam int WDAY_POS  = 42;
  localparam int MON_U_POS = 45;
  localparam int MON_T_POS = 49;
  localparam int YR_U_POS  = 50;
  localparam int YR_T_POS  = 54;

  // Decoded calendar fields.
  typedef struct packed {
    logic [6:0] minutes;
    logic [5:0] hours;
    logic [5:0] day;
    logic [2:0] weekday;
    logic [4:0] month;
    logic [7:0] year;
  } dcf_time_t;

  // Units digit plus ten times the tens digit, digits taken as they stand.
  function automatic logic [7:0] bcd2bin(input logic [3:0] units, input logic [3:0] tens);
    logic [7:0] t8;
    t8 = {4'b0000, tens};
    return {4'b0000, units} + (t8 << 3) + (t8 << 1);
  endfunction

endpackage

// ----- rtl/dcf_bcd_decode.sv -----
// Decodes the BCD calendar fields of one minute frame from the bit store.
module dcf_bcd_decode (
  input  logic [63:0]          store,
  output dcf_pkg::dcf_time_t   dec_o
);
  import dcf_pkg::*;

  logic [7:0] min_w, hr_w, day_w, mon_w, yr_w;

  // Each field is units plus ten times tens, no range check.
  always_comb begin
    min_w = bcd2bin(store[MIN_U_POS +: 4], {1'b0, store[MIN_T_POS +: 3]});
    hr_w  = bcd2bin(store[HR_U_POS +: 4], {2'b00, store[HR_T_POS +: 2]});
    day_w = bcd2bin(store[DAY_U_POS +: 4], {2'b00, store[DAY_T_POS +: 2]});
    mon_w = bcd2bin(store[MON_U_POS +: 4], {3'b000, store[MON_T_POS]});
    yr_w  = bcd2bin(store[YR_U_POS +: 4], store[YR_T_POS +: 4]);

    dec_o.minutes = min_w[6:0];
    dec_o.hours   = hr_w[5:0];
    dec_o.day     = day_w[5:0];
    dec_o.weekday = store[WDAY_POS +: 3];
    dec_o.month   = mon_w[4:0];
    dec_o.year    = yr_w;
  end

endmodule

// ----- rtl/dcf77_pulse_decoder.sv -----
// Top level of the DCF77 pulse decoder: edge filter, pulse timing and minute decode.
//
//  Channel  Direction  Handshake        Payload
//  in_      input      valid / stall    edge_time_us
//  out_     output     valid / stall    edge_accepted .. year_in_century
//  cfg_     input      we (no wait)     index, data
//
// Each request is held in the input register and then moves to the result
// register; the path between them is the timestamp subtracts, compares and store update.
// A new request is taken every cycle while out_ is not stalled.
// Reset is synchronous, active low, and restores the control and state registers.
// A stalled result holds; the input register fills behind it and then stalls in_.
`include "dcf77_pulse_decoder_defines.svh"

module dcf77_pulse_decoder #(
  parameter int TIME_BITS = dcf_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [dcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dcf_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Edge requests
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dcf_pkg::IN_TIME_W-1:0]    in_edge_time_us,
  // Results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_edge_accepted,
  output logic                             out_new_minute,
  output logic                             out_bit_done,
  output logic                             out_bit_value,
  output logic [5:0]                       out_second_index,
  output logic                             out_time_valid,
  output logic [6:0]                       out_minutes,
  output logic [5:0]                       out_hours,
  output logic [5:0]                       out_day_of_month,
  output logic [2:0]                       out_weekday,
  output logic [4:0]                       out_month,
  output logic [7:0]                       out_year_in_century
);
  import dcf_pkg::*;

  // Configuration registers
  logic [JITTER_W-1:0] jitter_r;
  logic [MINUTE_W-1:0] minute_gap_r;
  logic [ONE_W-1:0]    one_pulse_r;

  // Decoder state
  logic                 line_level_r, line_level_nxt;
  logic [TIME_BITS-1:0] last_edge_r;
  logic [TIME_BITS-1:0] rise_time_r, rise_time_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [SEC_W-1:0]     sec_cnt_r, sec_cnt_nxt;
  logic [STORE_W-1:0]   store_r, store_nxt;
  dcf_time_t            dec_r, dec_nxt, dec_frame;

  // Input register
  logic                 s1_valid_r;
  logic [IN_TIME_W-1:0] s1_time_r;
  logic                 s1_adv;
  logic                 in_take;

  // Result register
  logic out_valid_r;

  // Per-request combinational results
  logic [TIME_BITS-1:0] now, gap, width;
  logic                 acc, minute, done, bitv;
  logic [1:0]           phase_m;
  logic [SEC_W-1:0]     sec_m;
  logic [STORE_W-1:0]   store_m;

  // Handshake: the input register moves on whenever the result register is free.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Calendar decode of the frame held in the bit store.
  dcf_bcd_decode u_bcd (
    .store (store_r),
    .dec_o (dec_frame)
  );

  // Edge filter, minute boundary and pulse classification.
  always_comb begin
    now   = TIME_BITS'(s1_time_r);
    gap   = now - last_edge_r;
    width = now - rise_time_r;
    acc   = gap > TIME_BITS'(jitter_r);
    minute = acc && (gap > TIME_BITS'(minute_gap_r));

    phase_m = phase_r;
    sec_m   = sec_cnt_r;
    store_m = store_r;
    dec_nxt = dec_r;
    if (minute) begin
      if (phase_r != PHASE_UNSYNCED) begin
        phase_m = PHASE_STARTED;
        dec_nxt = dec_frame;
      end else begin
        phase_m = PHASE_INIT;
      end
      sec_m   = '0;
      store_m = '0;
    end

    done          = acc && line_level_r;
    bitv          = done && (width > TIME_BITS'(one_pulse_r)) && (phase_m != PHASE_UNSYNCED);
    phase_nxt     = phase_m;
    store_nxt     = store_m;
    rise_time_nxt = (acc && !line_level_r) ? now : rise_time_r;
    line_level_nxt = line_level_r ^ acc;
  end

  // Second counter update at a falling edge.
  always_comb begin
    sec_cnt_nxt = sec_m;
    if (done && (sec_m != SEC_MAX)) begin
      sec_cnt_nxt = sec_m + SEC_W'(1);
    end
  end

  // Configuration registers; an initial level write goes straight to the line level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jitter_r     <= JITTER_GAP_RST;
      minute_gap_r <= MINUTE_GAP_RST;
      one_pulse_r  <= ONE_PULSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_JITTER_GAP: jitter_r     <= cfg_data[JITTER_W-1:0];
        REG_MINUTE_GAP: minute_gap_r <= cfg_data[MINUTE_W-1:0];
        REG_ONE_PULSE:  one_pulse_r  <= cfg_data[ONE_W-1:0];
        default: ;
      endcase
    end
  end

  // Decoder state advances as each request leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_level_r <= INIT_LEVEL_RST;
      last_edge_r  <= '0;
      rise_time_r  <= '0;
      phase_r      <= PHASE_UNSYNCED;
      sec_cnt_r    <= '0;
      store_r      <= '0;
      dec_r        <= '0;
    end else begin
      if (s1_adv) begin
        line_level_r <= line_level_nxt;
        last_edge_r  <= now;
        rise_time_r  <= rise_time_nxt;
        phase_r      <= phase_nxt;
        sec_cnt_r    <= sec_cnt_nxt;
        store_r      <= bitv ? (store_nxt | (STORE_W'(1) << sec_m)) : store_nxt;
        dec_r        <= dec_nxt;
      end
      if (cfg_we && (cfg_index == REG_INIT_LEVEL)) begin
        line_level_r <= cfg_data[0];
      end
    end
  end

  // Input register valid and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_time_r <= in_edge_time_us;
    end
  end

  // Result register valid and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_edge_accepted   <= acc;
      out_new_minute      <= minute;
      out_bit_done        <= done;
      out_bit_value       <= bitv;
      out_second_index    <= sec_cnt_nxt;
      out_time_valid      <= (phase_nxt == PHASE_STARTED);
      out_minutes         <= dec_nxt.minutes;
      out_hours           <= dec_nxt.hours;
      out_day_of_month    <= dec_nxt.day;
      out_weekday         <= dec_nxt.weekday;
      out_month           <= dec_nxt.month;
      out_year_in_century <= dec_nxt.year;
    end
  end

  // A minute boundary restarts the second count, so the index is at most one.
  `DCF_ASSERT_SAME(a_minute_restarts, clk, rst_n,
    out_valid && out_new_minute, out_edge_accepted && (out_second_index <= 6'd1),
    "minute result with large second index")

  // A completed pulse belongs to an accepted edge and has counted a second.
  `DCF_ASSERT_SAME(a_bit_counts, clk, rst_n,
    out_valid && out_bit_done, out_edge_accepted && (out_second_index != 6'd0),
    "completed pulse without second count")

  // A rejected edge leaves the line level and the pulse start alone.
  `DCF_ASSERT_NEXT(a_reject_holds, clk, rst_n,
    s1_adv && !acc && !cfg_we, $stable(line_level_r) && $stable(rise_time_r),
    "rejected edge changed line state")

endmodule
